FILE: sv/mjt_pkg.sv
// ----------------------------------------------------------------------------
// mjt_pkg
// Types and codes shared by the job timer table, its checker and its bench.
// ----------------------------------------------------------------------------
package mjt_pkg;

  // Command codes carried in the cmd field of an input word.
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_ADD     = 2'd1,
    CMD_CANCEL  = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_FULL     = 3'd2,
    ST_CANCELED = 3'd3,
    ST_BUSY     = 3'd4,
    ST_RUNNING  = 3'd5
  } status_e;

  // Life cycle of one slot.
  typedef enum logic [1:0] {
    PH_FREE   = 2'd0,
    PH_RUN    = 2'd1,
    PH_CANCEL = 2'd2,
    PH_OVER   = 2'd3
  } phase_e;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_WALK,
    S_ADD_SCAN,
    S_SLOT_RD,
    S_FINISH
  } mjt_state_e;

  localparam int unsigned PhaseW = 2;

endpackage

FILE: sv/mjt_if.sv
// ----------------------------------------------------------------------------
// mjt_in_if / mjt_out_if
// Valid/ready channels carrying command words into and result words out of
// the job timer table.
// ----------------------------------------------------------------------------
interface mjt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] period;
  logic        periodic;
  logic [4:0]  slot_id;

  modport source (output valid, cmd, period, periodic, slot_id, input ready);
  modport sink   (input valid, cmd, period, periodic, slot_id, output ready);
endinterface

interface mjt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [4:0]  slot_out;
  logic [31:0] expired_mask;

  modport source (output valid, status, slot_out, expired_mask, input ready);
  modport sink   (input valid, status, slot_out, expired_mask, output ready);
endinterface

FILE: sv/multi_slot_job_timer.sv
// ----------------------------------------------------------------------------
// multi_slot_job_timer
// Table of one-shot and periodic timer slots driven by tick, add, cancel and
// release commands, with the slot state held in a slot memory.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and returns one result word for
// it. A tick walks every slot through the slot memory, one read and one
// write-back per cycle. An add scans the allocation flags from slot 0 one
// slot per cycle and stops at the first free slot, or at the end of the
// table when it is full. Cancel and release read the addressed slot; those
// refused at once for a bad or free slot do not read it. A result waiting in
// the output register does not stop the next command being accepted; only
// the hand-over of a further result waits for it.
// ----------------------------------------------------------------------------
module multi_slot_job_timer import mjt_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mjt_in_if.sink    in_i,
  mjt_out_if.source out_o
);

  localparam int unsigned IdxW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW     = $clog2(NUM_SLOTS + 1);
  localparam int unsigned FlagPos  = 2 * COUNT_BITS;
  localparam int unsigned PhaseLo  = FlagPos + 1;
  localparam int unsigned WordW    = PhaseLo + PhaseW;
  localparam logic [63:0] CountMax = (64'd1 << COUNT_BITS) - 64'd1;
  localparam logic [CntW-1:0] LastCnt = CntW'(NUM_SLOTS);

  mjt_state_e state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  pend_q, pend_d;
  logic [IdxW-1:0]       pidx_q;
  logic [NUM_SLOTS-1:0]  busy_q, busy_d;
  logic [31:0]           mask_q, mask_d;
  status_e               status_q, status_d;
  logic [4:0]            slot_q, slot_d;

  // Captured command word.
  cmd_e                  cmd_q;
  logic [IdxW-1:0]       sid_q;
  logic [COUNT_BITS-1:0] period_q;
  logic                  periodic_q;

  // Slot memory: {phase, reload flag, reload value, ticks left}.
  logic [WordW-1:0]      slot_mem_q [NUM_SLOTS];
  logic [WordW-1:0]      rdata_q;
  logic [WordW-1:0]      wdata;
  logic [IdxW-1:0]       rd_addr;
  logic [IdxW-1:0]       wr_addr;
  logic                  we;

  // Output register.
  logic                  ovalid_q;
  status_e               ostatus_q;
  logic [4:0]            oslot_q;
  logic [31:0]           omask_q;
  logic                  load_out;

  logic                  in_ready;
  logic                  in_take;
  logic [IdxW-1:0]       sid_in;
  logic                  id_bad;
  logic                  period_bad;
  logic [IdxW-1:0]       cidx;
  phase_e                rd_phase;
  logic                  rd_flag;
  logic [COUNT_BITS-1:0] rd_ticks;
  logic [COUNT_BITS-1:0] rd_reload;
  logic [COUNT_BITS-1:0] tick_dec;

  assign in_take    = in_i.valid && in_ready;
  assign sid_in     = IdxW'(in_i.slot_id);
  assign id_bad     = 32'(in_i.slot_id) >= NUM_SLOTS;
  assign period_bad = (in_i.period == 16'd0) || ({48'd0, in_i.period} > CountMax);
  assign cidx       = cnt_q[IdxW-1:0];

  // Fields of the word read back from the slot memory.
  assign rd_phase  = phase_e'(rdata_q[PhaseLo +: PhaseW]);
  assign rd_flag   = rdata_q[FlagPos];
  assign rd_reload = rdata_q[COUNT_BITS +: COUNT_BITS];
  assign rd_ticks  = rdata_q[COUNT_BITS-1:0];
  assign tick_dec  = rd_ticks - COUNT_BITS'(1);

  // Sequencer: next state, memory access and result.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pend_d   = 1'b0;
    busy_d   = busy_q;
    mask_d   = mask_q;
    status_d = status_q;
    slot_d   = slot_q;
    rd_addr  = cidx;
    wr_addr  = pidx_q;
    wdata    = rdata_q;
    we       = 1'b0;
    load_out = 1'b0;
    in_ready = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = sid_in;
        if (in_i.valid) begin
          cnt_d    = '0;
          mask_d   = '0;
          slot_d   = '0;
          status_d = ST_OK;
          unique case (cmd_e'(in_i.cmd))
            CMD_TICK: begin
              state_d = S_TICK_WALK;
            end
            CMD_ADD: begin
              if (period_bad) begin
                status_d = ST_INVALID;
                state_d  = S_FINISH;
              end else begin
                state_d = S_ADD_SCAN;
              end
            end
            CMD_CANCEL, CMD_RELEASE: begin
              if (id_bad || !busy_q[sid_in]) begin
                status_d = ST_INVALID;
                state_d  = S_FINISH;
              end else begin
                state_d = S_SLOT_RD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // Read slot cnt while slot cnt-1 is updated and written back.
      S_TICK_WALK: begin
        if (cnt_q != LastCnt) begin
          pend_d = 1'b1;
          cnt_d  = cnt_q + CntW'(1);
        end else begin
          state_d = S_FINISH;
        end
        if (pend_q && busy_q[pidx_q] && rd_phase == PH_RUN) begin
          we                    = 1'b1;
          wdata[COUNT_BITS-1:0] = tick_dec;
          if (tick_dec == '0) begin
            mask_d = mask_q | (32'd1 << pidx_q);
            if (rd_flag) begin
              wdata[COUNT_BITS-1:0] = rd_reload;
            end else begin
              wdata[PhaseLo +: PhaseW] = PH_OVER;
            end
          end
        end
      end

      // Look for the lowest free slot, one slot per cycle.
      S_ADD_SCAN: begin
        if (cnt_q == LastCnt) begin
          status_d = ST_FULL;
          state_d  = S_FINISH;
        end else if (!busy_q[cidx]) begin
          we           = 1'b1;
          wr_addr      = cidx;
          wdata        = {PH_RUN, periodic_q, period_q, period_q};
          busy_d[cidx] = 1'b1;
          slot_d       = 5'(cidx);
          status_d     = ST_OK;
          state_d      = S_FINISH;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end

      // The addressed slot is in rdata_q; decide and write back.
      S_SLOT_RD: begin
        wr_addr = sid_q;
        state_d = S_FINISH;
        if (cmd_q == CMD_CANCEL) begin
          unique case (rd_phase)
            PH_CANCEL: status_d = ST_CANCELED;
            PH_OVER:   status_d = ST_BUSY;
            PH_RUN, PH_FREE: begin
              we                       = 1'b1;
              wdata[PhaseLo +: PhaseW] = PH_CANCEL;
            end
            default: status_d = ST_INVALID;
          endcase
        end else begin
          priority if (rd_flag) begin
            status_d = ST_BUSY;
          end else if (rd_phase == PH_RUN) begin
            status_d = ST_RUNNING;
          end else begin
            busy_d[sid_q] = 1'b0;
          end
        end
      end

      // Hand the result to the output register once it is free.
      S_FINISH: begin
        if (!ovalid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      pend_q   <= 1'b0;
      busy_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      busy_q  <= busy_d;
      if (load_out) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Payload registers: command capture, result and output word.
  always_ff @(posedge clk_i) begin
    pidx_q   <= cidx;
    mask_q   <= mask_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    if (in_take) begin
      cmd_q      <= cmd_e'(in_i.cmd);
      sid_q      <= sid_in;
      period_q   <= COUNT_BITS'(in_i.period);
      periodic_q <= in_i.periodic;
    end
    if (load_out) begin
      ostatus_q <= status_q;
      oslot_q   <= slot_q;
      omask_q   <= mask_q;
    end
  end

  // Slot memory, one read and one write port, registered read data.
  always_ff @(posedge clk_i) begin
    rdata_q <= slot_mem_q[rd_addr];
    if (we) begin
      slot_mem_q[wr_addr] <= wdata;
    end
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = ovalid_q;
  assign out_o.status       = ostatus_q;
  assign out_o.slot_out     = oslot_q;
  assign out_o.expired_mask = omask_q;

endmodule

FILE: sv/mjt_checker.sv
// ----------------------------------------------------------------------------
// mjt_checker
// Port-level assertions for the job timer table, bound to its top level.
// ----------------------------------------------------------------------------
module mjt_checker import mjt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  status_i,
  input logic [4:0]  slot_out_i,
  input logic [31:0] expired_mask_i
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(slot_out_i) && $stable(expired_mask_i))
    else $error("stalled result word changed");

  // A refused command reports no slot and no expiry.
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |-> slot_out_i == 5'd0 && expired_mask_i == 32'd0)
    else $error("refused command carries slot or expiry bits");

  // Expiry bits only come from a tick, which reports no slot.
  a_tick_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && expired_mask_i != 32'd0 |-> slot_out_i == 5'd0)
    else $error("expiry reported together with a slot");

  // One command at a time: the block is busy after taking a word.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command taken while the previous one is at work");

endmodule

bind multi_slot_job_timer mjt_checker u_mjt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .status_i       (out_o.status),
  .slot_out_i     (out_o.slot_out),
  .expired_mask_i (out_o.expired_mask)
);

FILE: dv/multi_slot_job_timer_test.sv
// ----------------------------------------------------------------------------
// multi_slot_job_timer_test
// Self-checking bench for the job timer table.
// ----------------------------------------------------------------------------
// Command words go in through the input channel. A predictor keeps its own
// copy of the slot table and works out the result word for each accepted
// command. A checker compares every result word with the oldest prediction,
// field by field. The directed tests cover each command and refusal. The
// random tests then run under three idling patterns on the two channels.
// ----------------------------------------------------------------------------
module multi_slot_job_timer_test;
  import mjt_pkg::*;

  localparam int unsigned Slots      = 32;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainWait  = Slots + 8;

  // One predicted result word.
  typedef struct packed {
    status_e     status;
    logic [4:0]  slot;
    logic [31:0] mask;
  } reply_t;

  logic clk_i;
  logic rst_ni;

  mjt_in_if  in_ch ();
  mjt_out_if out_ch ();

  multi_slot_job_timer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Predicted copy of the slot table.
  phase_e      slot_phase   [Slots];
  logic [15:0] slot_reload  [Slots];
  logic [15:0] slot_count   [Slots];
  logic        slot_repeats [Slots];

  reply_t      awaited_replies [$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Works out the reply to one command and updates the predicted table.
  function automatic reply_t timer_table_response(cmd_e cmd, logic [15:0] period,
                                                  logic periodic, logic [4:0] id);
    reply_t r;
    r = '{status: ST_OK, slot: '0, mask: '0};
    case (cmd)
      CMD_TICK: begin
        for (int i = 0; i < Slots; i++) begin
          if (slot_phase[i] == PH_RUN) begin
            slot_count[i] = slot_count[i] - 16'd1;
            if (slot_count[i] == 16'd0) begin
              r.mask[i] = 1'b1;
              if (slot_repeats[i]) slot_count[i] = slot_reload[i];
              else slot_phase[i] = PH_OVER;
            end
          end
        end
      end
      CMD_ADD: begin
        if (period == 16'd0) begin
          r.status = ST_INVALID;
        end else begin
          r.status = ST_FULL;
          for (int i = 0; i < Slots; i++) begin
            if (r.status == ST_FULL && slot_phase[i] == PH_FREE) begin
              slot_phase[i]   = PH_RUN;
              slot_reload[i]  = period;
              slot_count[i]   = period;
              slot_repeats[i] = periodic;
              r.status        = ST_OK;
              r.slot          = i[4:0];
            end
          end
        end
      end
      CMD_CANCEL: begin
        if (slot_phase[id] == PH_FREE) r.status = ST_INVALID;
        else if (slot_phase[id] == PH_CANCEL) r.status = ST_CANCELED;
        else if (slot_phase[id] == PH_OVER) r.status = ST_BUSY;
        else slot_phase[id] = PH_CANCEL;
      end
      default: begin
        if (slot_phase[id] == PH_FREE) r.status = ST_INVALID;
        else if (slot_repeats[id]) r.status = ST_BUSY;
        else if (slot_phase[id] == PH_RUN) r.status = ST_RUNNING;
        else slot_phase[id] = PH_FREE;
      end
    endcase
    return r;
  endfunction

  // Number of free slots in the predicted table.
  function automatic int unsigned free_slot_count();
    int unsigned n;
    n = 0;
    for (int i = 0; i < Slots; i++) begin
      if (slot_phase[i] == PH_FREE) n++;
    end
    return n;
  endfunction

  // Mostly an occupied slot, otherwise any slot at all.
  function automatic logic [4:0] pick_target_slot();
    int unsigned taken [$];
    for (int i = 0; i < Slots; i++) begin
      if (slot_phase[i] != PH_FREE) taken.push_back(i);
    end
    if (taken.size() == 0 || $urandom_range(99) < 15) return 5'($urandom_range(Slots - 1));
    return 5'(taken[$urandom_range(taken.size() - 1)]);
  endfunction

  // Sends one command word, with random idle cycles in front of it.
  task automatic send_command(cmd_e cmd, logic [15:0] period, logic periodic,
                              logic [4:0] id);
    reply_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid    = 1'b1;
    in_ch.cmd      = cmd;
    in_ch.period   = period;
    in_ch.periodic = periodic;
    in_ch.slot_id  = id;
    r = timer_table_response(cmd, period, periodic, id);
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    awaited_replies.push_back(r);
  endtask

  // Every command and each refusal but a full table, on a table that starts empty.
  task automatic test_basic_commands();
    send_command(CMD_TICK, 16'd0, 1'b0, 5'd0);
    send_command(CMD_ADD, 16'd0, 1'b1, 5'd31);
    send_command(CMD_CANCEL, 16'hFFFF, 1'b1, 5'd0);
    send_command(CMD_RELEASE, 16'd0, 1'b0, 5'd31);
    send_command(CMD_ADD, 16'd1, 1'b0, 5'd0);
    send_command(CMD_ADD, 16'hFFFF, 1'b1, 5'd0);
    send_command(CMD_ADD, 16'd2, 1'b1, 5'd0);
    send_command(CMD_ADD, 16'd3, 1'b0, 5'd0);
    send_command(CMD_RELEASE, 16'd0, 1'b0, 5'd0);
    send_command(CMD_RELEASE, 16'd0, 1'b0, 5'd1);
    send_command(CMD_TICK, 16'd0, 1'b0, 5'd0);
    send_command(CMD_CANCEL, 16'd0, 1'b0, 5'd0);
    send_command(CMD_TICK, 16'd0, 1'b0, 5'd0);
    send_command(CMD_CANCEL, 16'd0, 1'b0, 5'd3);
    send_command(CMD_CANCEL, 16'd0, 1'b0, 5'd3);
    send_command(CMD_RELEASE, 16'd0, 1'b0, 5'd3);
    send_command(CMD_RELEASE, 16'd0, 1'b0, 5'd0);
    send_command(CMD_TICK, 16'd0, 1'b0, 5'd0);
    send_command(CMD_TICK, 16'd0, 1'b0, 5'd0);
    send_command(CMD_CANCEL, 16'd0, 1'b0, 5'd2);
    send_command(CMD_RELEASE, 16'd0, 1'b0, 5'd2);
    send_command(CMD_CANCEL, 16'd0, 1'b0, 5'd1);
    send_command(CMD_ADD, 16'hAAAA, 1'b0, 5'd0);
    send_command(CMD_ADD, 16'h5555, 1'b0, 5'd0);
  endtask

  // Fills the table until adds are refused, then frees every one-shot slot.
  task automatic test_full_table();
    while (free_slot_count() != 0) begin
      send_command(CMD_ADD, 16'd40000, 1'b0, 5'd0);
    end
    send_command(CMD_ADD, 16'd7, 1'b0, 5'd0);
    send_command(CMD_ADD, 16'd9, 1'b1, 5'd0);
    send_command(CMD_TICK, 16'd0, 1'b0, 5'd0);
    for (int i = 0; i < Slots; i++) begin
      if (!slot_repeats[i]) begin
        send_command(CMD_CANCEL, 16'd0, 1'b0, i[4:0]);
        send_command(CMD_RELEASE, 16'd0, 1'b0, i[4:0]);
      end
    end
  endtask

  // Random mix of mostly sensible commands, with some noise among them.
  task automatic test_random_mix(int unsigned n);
    int unsigned pick;
    logic [15:0] period;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_command(CMD_TICK, 16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)),
                     5'($urandom_range(Slots - 1)));
      end else if (pick < 60) begin
        period = ($urandom_range(9) == 0) ? 16'($urandom_range(16'hFFFF))
                                          : 16'($urandom_range(1, 6));
        send_command(CMD_ADD, period, $urandom_range(199) < 3,
                     5'($urandom_range(Slots - 1)));
      end else if (pick < 80) begin
        send_command(CMD_CANCEL, 16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)),
                     pick_target_slot());
      end else begin
        send_command(CMD_RELEASE, 16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)),
                     pick_target_slot());
      end
    end
  endtask

  // Waits for the last replies, lets the block settle and reports.
  task automatic finish_run();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      error_count++;
    end
  endtask

  // Random back-pressure on the result channel.
  always @(negedge clk_i) begin
    out_ch.ready = ($urandom_range(99) >= snk_stall_pct);
  end

  // Compares each result word with the oldest prediction.
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual status %0d",
                 $time, out_ch.status);
        error_count++;
      end else begin
        want = awaited_replies.pop_front();
        check_field("status", want.status, out_ch.status);
        check_field("slot_out", want.slot, out_ch.slot_out);
        check_field("expired_mask", want.mask, out_ch.expired_mask);
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_TICK;
    in_ch.period   = '0;
    in_ch.periodic = 1'b0;
    in_ch.slot_id  = '0;
    out_ch.ready   = 1'b0;
    error_count    = 0;
    cycle_count    = 0;
    src_idle_pct   = 12;
    snk_stall_pct  = 64;
    for (int i = 0; i < Slots; i++) begin
      slot_phase[i]   = PH_FREE;
      slot_reload[i]  = '0;
      slot_count[i]   = '0;
      slot_repeats[i] = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_commands();
    test_full_table();
    test_random_mix(650);
    src_idle_pct  = 64;
    snk_stall_pct = 12;
    test_random_mix(650);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    test_random_mix(650);
    finish_run();
  end

endmodule

FILE: multi_slot_job_timer.f
sv/mjt_pkg.sv
sv/mjt_if.sv
sv/multi_slot_job_timer.sv
sv/mjt_checker.sv
dv/multi_slot_job_timer_test.sv
